>>> rtl/core/irqlp_pkg.sv
// Types, codes and helper functions shared by the interrupt latency profiler.
// Depends on nothing; every other file of the block but irqlp_div imports it.
`default_nettype none
package irqlp_pkg;

  typedef enum logic [2:0] {
    OP_EARLY = 3'd0,
    OP_ENTER = 3'd1,
    OP_EXIT  = 3'd2,
    OP_DEFER = 3'd3,
    OP_LEAVE = 3'd4,
    OP_QUERY = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    K_EARLY,
    K_ENTER,
    K_EXIT,
    K_DEFER,
    K_LEAVE,
    K_QUERY,
    K_QBAD
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_OUT
  } state_t;

  localparam logic [15:0] TPU_RESET = 16'd24;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  irq_number;
    logic [63:0] timestamp;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [31:0] entry_latency_us;
    logic [31:0] handler_us;
    logic [31:0] deferred_latency_us;
    logic [31:0] deferred_us;
    logic [31:0] worst_total_us;
    logic [31:0] average_us;
  } out_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  irq_number;
    logic [63:0] timestamp;
  } q_item_t;

  typedef struct packed {
    logic [63:0] entry_start;
    logic [63:0] last_event;
    logic [31:0] w_entry;
    logic [31:0] w_handler;
    logic [31:0] w_dwait;
    logic [31:0] w_drun;
    logic [31:0] acc_us;
    logic [31:0] worst_us;
    logic [31:0] count;
  } row_t;

  function automatic logic [31:0] umax32(input logic [31:0] a, input logic [31:0] b);
    umax32 = (b > a) ? b : a;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/irqlp_fifo.sv
// Two-entry request queue between the front and back parts of the profiler.
// Depends on irqlp_pkg for the queued request type.
`default_nettype none
module irqlp_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire irqlp_pkg::q_item_t push_item,
  output logic                   full,
  input  wire logic              pop,
  output logic                   not_empty,
  output irqlp_pkg::q_item_t     head
);
  import irqlp_pkg::*;

  q_item_t    mem_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = mem_r[rp_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= ~wp_r;
      end
      if (do_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/irqlp_front.sv
// Front part: accepts requests, checks the interrupt number and classifies them.
// Depends on irqlp_pkg; feeds irqlp_fifo.
`default_nettype none
module irqlp_front #(
  parameter int IRQ_COUNT = 128
) (
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire irqlp_pkg::in_item_t in_data,
  input  wire logic               clearing,
  input  wire logic               q_full,
  output logic                    push,
  output irqlp_pkg::q_item_t      push_item
);
  import irqlp_pkg::*;

  logic ok;
  logic keep;

  assign ok       = ({1'b0, in_data.irq_number} < 9'(IRQ_COUNT));
  assign in_ready = !clearing && !q_full;
  assign push     = in_valid && in_ready && keep;

  always_comb begin
    keep                 = 1'b0;
    push_item.kind       = K_EARLY;
    push_item.irq_number = in_data.irq_number;
    push_item.timestamp  = in_data.timestamp;
    case (op_t'(in_data.op))
      OP_EARLY: begin
        keep = 1'b1;
      end
      OP_ENTER: begin
        keep           = ok;
        push_item.kind = K_ENTER;
      end
      OP_EXIT: begin
        keep           = ok;
        push_item.kind = K_EXIT;
      end
      OP_DEFER: begin
        keep           = ok;
        push_item.kind = K_DEFER;
      end
      OP_LEAVE: begin
        keep           = ok;
        push_item.kind = K_LEAVE;
      end
      OP_QUERY: begin
        keep           = 1'b1;
        push_item.kind = ok ? K_QUERY : K_QBAD;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/core/irqlp_div.sv
// Restoring 32-bit divider, one quotient bit per cycle.
// Depends on nothing; shared by all conversions of the back part.
`default_nettype none
module irqlp_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [31:0]      quotient
);
  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [32:0] rem_r;
  logic [31:0] quo_r;
  logic [31:0] dvs_r;
  logic [32:0] rem_sh;
  logic        ge;

  assign rem_sh   = {rem_r[31:0], quo_r[31]};
  assign ge       = (rem_sh >= {1'b0, dvs_r});
  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
      quo_r <= {quo_r[30:0], ge};
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/irqlp_back.sv
// Back part: per-interrupt table memory, update sequencer and query results.
// Depends on irqlp_pkg and irqlp_div.
`default_nettype none
module irqlp_back #(
  parameter int IRQ_COUNT = 128
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [15:0]        tpu,
  input  wire logic               q_valid,
  input  wire irqlp_pkg::q_item_t q_item,
  output logic                    q_pop,
  output logic                    clearing,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output irqlp_pkg::out_item_t    out_data
);
  import irqlp_pkg::*;

  localparam int AW = (IRQ_COUNT > 1) ? $clog2(IRQ_COUNT) : 1;

  row_t        mem [IRQ_COUNT];
  row_t        rd_data_r;
  state_t      state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  q_item_t     item_r, item_nxt;
  logic [63:0] global_r, global_nxt;
  logic [2:0]  qsel_r, qsel_nxt;
  out_item_t   res_r, res_nxt;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  row_t          wr_row;
  row_t          row;
  logic          dv_start;
  logic [31:0]   dv_dividend;
  logic [31:0]   dv_divisor;
  logic          dv_busy;
  logic          dv_done;
  logic [31:0]   dv_q;
  logic [31:0]   ent_d;
  logic [31:0]   run_d;
  logic [31:0]   tot_d;

  irqlp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dv_start),
    .dividend (dv_dividend),
    .divisor  (dv_divisor),
    .busy     (dv_busy),
    .done     (dv_done),
    .quotient (dv_q)
  );

  assign row       = rd_data_r;
  assign ent_d     = item_r.timestamp[31:0] - global_r[31:0];
  assign run_d     = item_r.timestamp[31:0] - row.last_event[31:0];
  assign tot_d     = item_r.timestamp[31:0] - row.entry_start[31:0];
  assign clearing  = (state_r == ST_CLEAR);
  assign out_valid = (state_r == ST_OUT);
  assign out_data  = res_r;

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    item_nxt    = item_r;
    global_nxt  = global_r;
    qsel_nxt    = qsel_r;
    res_nxt     = res_r;
    q_pop       = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = q_item.irq_number[AW-1:0];
    wr_en       = 1'b0;
    wr_addr     = item_r.irq_number[AW-1:0];
    wr_row      = row;
    dv_start    = 1'b0;
    dv_dividend = row.w_entry;
    dv_divisor  = {16'd0, tpu};
    case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt_r;
        wr_row  = '0;
        if (clr_cnt_r == AW'(IRQ_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          item_nxt = q_item;
          case (q_item.kind)
            K_EARLY: begin
              global_nxt = q_item.timestamp;
            end
            K_QBAD: begin
              res_nxt        = '0;
              res_nxt.status = 1'b1;
              state_nxt      = ST_OUT;
            end
            default: begin
              rd_en     = 1'b1;
              state_nxt = ST_READ;
            end
          endcase
        end
      end
      ST_READ: begin
        case (item_r.kind)
          K_ENTER: begin
            wr_en              = 1'b1;
            wr_row.w_entry     = umax32(row.w_entry, ent_d);
            wr_row.count       = row.count + 32'd1;
            wr_row.entry_start = global_r;
            wr_row.last_event  = item_r.timestamp;
            state_nxt          = ST_IDLE;
          end
          K_EXIT: begin
            wr_en             = 1'b1;
            wr_row.w_handler  = umax32(row.w_handler, run_d);
            wr_row.last_event = item_r.timestamp;
            state_nxt         = ST_IDLE;
          end
          K_DEFER: begin
            wr_en             = 1'b1;
            wr_row.w_dwait    = umax32(row.w_dwait, run_d);
            wr_row.last_event = item_r.timestamp;
            state_nxt         = ST_IDLE;
          end
          K_LEAVE: begin
            dv_start    = 1'b1;
            dv_dividend = tot_d;
            state_nxt   = ST_DIV;
          end
          default: begin
            res_nxt     = '0;
            dv_start    = 1'b1;
            dv_dividend = row.w_entry;
            qsel_nxt    = 3'd0;
            state_nxt   = ST_DIV;
          end
        endcase
      end
      ST_DIV: begin
        if (dv_done) begin
          if (item_r.kind == K_LEAVE) begin
            wr_en             = 1'b1;
            wr_row.w_drun     = umax32(row.w_drun, run_d);
            wr_row.last_event = item_r.timestamp;
            wr_row.worst_us   = umax32(row.worst_us, dv_q);
            wr_row.acc_us     = row.acc_us + dv_q;
            state_nxt         = ST_IDLE;
          end else begin
            case (qsel_r)
              3'd0: begin
                res_nxt.entry_latency_us = dv_q;
                dv_start    = 1'b1;
                dv_dividend = row.w_handler;
                qsel_nxt    = 3'd1;
              end
              3'd1: begin
                res_nxt.handler_us = dv_q;
                dv_start    = 1'b1;
                dv_dividend = row.w_dwait;
                qsel_nxt    = 3'd2;
              end
              3'd2: begin
                res_nxt.deferred_latency_us = dv_q;
                dv_start    = 1'b1;
                dv_dividend = row.w_drun;
                qsel_nxt    = 3'd3;
              end
              3'd3: begin
                res_nxt.deferred_us    = dv_q;
                res_nxt.worst_total_us = row.worst_us;
                if (row.count != 32'd0) begin
                  dv_start    = 1'b1;
                  dv_dividend = row.acc_us;
                  dv_divisor  = row.count;
                  qsel_nxt    = 3'd4;
                end else begin
                  res_nxt.average_us = 32'd0;
                  state_nxt          = ST_OUT;
                end
              end
              default: begin
                res_nxt.average_us = dv_q;
                state_nxt          = ST_OUT;
              end
            endcase
          end
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
      global_r  <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      global_r  <= global_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    qsel_r <= qsel_nxt;
    res_r  <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  a_start_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    dv_start |-> !dv_busy)
    else $error("divider started while busy");
  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == ST_IDLE))
    else $error("queue popped outside idle");
  a_no_write_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!wr_en && !dv_busy))
    else $error("table or divider active while result is pending");
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (dv_busy || dv_done))
    else $error("waiting for an idle divider");

endmodule
`default_nettype wire

>>> rtl/core/irq_latency_profiler.sv
// Interrupt latency profiler top: holds the tick divisor register and joins
// irqlp_front, irqlp_fifo and irqlp_back (which uses irqlp_div); needs irqlp_pkg.
// Early entries are taken at once; enter, exit and defer read the row and write it;
// leave adds a divider pass; a query runs one pass per divided result, then out_valid.
// Throughput is one request at a time in the back part; the divider sets the pace.
// After reset the table is cleared row by row while in_ready stays low.
`default_nettype none
module irq_latency_profiler #(
  parameter int IRQ_COUNT = 128
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire irqlp_pkg::in_item_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output irqlp_pkg::out_item_t      out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [15:0]          cfg_data
);
  import irqlp_pkg::*;

  logic [15:0] tpu_r;
  logic        clearing;
  logic        q_full;
  logic        q_push;
  q_item_t     q_in;
  logic        q_pop;
  logic        q_valid;
  q_item_t     q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpu_r <= TPU_RESET;
    end else if (cfg_valid) begin
      tpu_r <= cfg_data;
    end
  end

  irqlp_front #(.IRQ_COUNT(IRQ_COUNT)) u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .clearing  (clearing),
    .q_full    (q_full),
    .push      (q_push),
    .push_item (q_in)
  );

  irqlp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  irqlp_back #(.IRQ_COUNT(IRQ_COUNT)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tpu       (tpu_r),
    .q_valid   (q_valid),
    .q_item    (q_head),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

>>> test/tb_irq_latency_profiler.sv
// Self-checking testbench for irq_latency_profiler: drives event and query
// requests, predicts every query result and compares it field by field.
// Depends on irqlp_pkg and the irq_latency_profiler RTL.
`timescale 1ns / 100ps
module tb_irq_latency_profiler;
  import irqlp_pkg::*;

  localparam int NIRQ = 128;
  localparam int STALL_LIMIT = 6000;
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [15:0] cfg_data;

  irq_latency_profiler #(.IRQ_COUNT(NIRQ)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Predicted profiler state.
  logic [15:0] tpu;
  logic [63:0] start_stamp;
  logic [63:0] entry_stamp [NIRQ];
  logic [63:0] last_stamp [NIRQ];
  logic [31:0] max_entry [NIRQ];
  logic [31:0] max_handler [NIRQ];
  logic [31:0] max_dwait [NIRQ];
  logic [31:0] max_drun [NIRQ];
  logic [31:0] sum_us [NIRQ];
  logic [31:0] max_us [NIRQ];
  logic [31:0] entries [NIRQ];

  out_item_t query_q [$];
  int errors;
  int idle_pct;
  int rx_hold;
  int hold_len;
  int hold_req;
  int hold_seen;
  int quiet_cycles;
  logic [63:0] now_ts;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] ticks_to_us(input logic [31:0] ticks);
    if (tpu == 0) return 32'hFFFF_FFFF;
    return ticks / tpu;
  endfunction

  function automatic logic [31:0] bigger(input logic [31:0] a, input logic [31:0] b);
    return (b > a) ? b : a;
  endfunction

  function automatic logic [63:0] next_ts();
    if ($urandom_range(99) < 3) now_ts = {$urandom, $urandom};
    else now_ts = now_ts + 64'($urandom_range(6000, 1));
    return now_ts;
  endfunction

  task automatic model_reset();
    tpu = TPU_RESET;
    start_stamp = '0;
    for (int i = 0; i < NIRQ; i++) begin
      entry_stamp[i] = '0;
      last_stamp[i] = '0;
      max_entry[i] = '0;
      max_handler[i] = '0;
      max_dwait[i] = '0;
      max_drun[i] = '0;
      sum_us[i] = '0;
      max_us[i] = '0;
      entries[i] = '0;
    end
  endtask

  task automatic profile_update(input in_item_t it);
    int n;
    logic [31:0] d;
    out_item_t r;
    n = it.irq_number;
    if (it.op == OP_EARLY) begin
      start_stamp = it.timestamp;
      return;
    end
    if (it.op == OP_QUERY) begin
      r = '0;
      if (n >= NIRQ) begin
        r.status = 1'b1;
      end else begin
        r.entry_latency_us = ticks_to_us(max_entry[n]);
        r.handler_us = ticks_to_us(max_handler[n]);
        r.deferred_latency_us = ticks_to_us(max_dwait[n]);
        r.deferred_us = ticks_to_us(max_drun[n]);
        r.worst_total_us = max_us[n];
        r.average_us = (entries[n] != 0) ? sum_us[n] / entries[n] : 32'd0;
      end
      query_q.push_back(r);
      return;
    end
    if (n >= NIRQ || it.op > OP_QUERY) return;
    case (it.op)
      OP_ENTER: begin
        max_entry[n] = bigger(max_entry[n], 32'(it.timestamp - start_stamp));
        entries[n] = entries[n] + 32'd1;
        entry_stamp[n] = start_stamp;
      end
      OP_EXIT: max_handler[n] = bigger(max_handler[n], 32'(it.timestamp - last_stamp[n]));
      OP_DEFER: max_dwait[n] = bigger(max_dwait[n], 32'(it.timestamp - last_stamp[n]));
      default: begin
        max_drun[n] = bigger(max_drun[n], 32'(it.timestamp - last_stamp[n]));
        d = ticks_to_us(32'(it.timestamp - entry_stamp[n]));
        max_us[n] = bigger(max_us[n], d);
        sum_us[n] = sum_us[n] + d;
      end
    endcase
    last_stamp[n] = it.timestamp;
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    out_item_t w;
    if (rst_n && out_valid && out_ready) begin
      if (query_q.size() == 0) begin
        report("unexpected result", 32'd1, 32'd0);
      end else begin
        w = query_q.pop_front();
        if (out_data.status !== w.status) report("status", out_data.status, w.status);
        if (out_data.entry_latency_us !== w.entry_latency_us)
          report("entry_latency_us", out_data.entry_latency_us, w.entry_latency_us);
        if (out_data.handler_us !== w.handler_us)
          report("handler_us", out_data.handler_us, w.handler_us);
        if (out_data.deferred_latency_us !== w.deferred_latency_us)
          report("deferred_latency_us", out_data.deferred_latency_us, w.deferred_latency_us);
        if (out_data.deferred_us !== w.deferred_us)
          report("deferred_us", out_data.deferred_us, w.deferred_us);
        if (out_data.worst_total_us !== w.worst_total_us)
          report("worst_total_us", out_data.worst_total_us, w.worst_total_us);
        if (out_data.average_us !== w.average_us)
          report("average_us", out_data.average_us, w.average_us);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_hold <= 0;
      hold_seen <= 0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      rx_hold <= hold_len;
      out_ready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Called at a rising edge; returns at the edge where the request is taken.
  task automatic send_item(input logic [2:0] op, input logic [7:0] n, input logic [63:0] ts);
    in_item_t it;
    it.op = op;
    it.irq_number = n;
    it.timestamp = ts;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    profile_update(it);
  endtask

  task automatic send_random(input int bad_pct);
    int r;
    logic [2:0] op;
    logic [7:0] n;
    r = $urandom_range(99);
    if (r < 15) op = OP_EARLY;
    else if (r < 32) op = OP_ENTER;
    else if (r < 47) op = OP_EXIT;
    else if (r < 60) op = OP_DEFER;
    else if (r < 78) op = OP_LEAVE;
    else op = OP_QUERY;
    if ($urandom_range(1) == 0) n = 8'($urandom_range(7));
    else n = 8'($urandom_range(NIRQ - 1));
    if ($urandom_range(99) < bad_pct) begin
      if ($urandom_range(2) == 0) op = ($urandom_range(1) == 0) ? OP_SPARE6 : OP_SPARE7;
      else n = 8'($urandom_range(255, NIRQ));
    end
    send_item(op, n, next_ts());
  endtask

  // A query is sent and every expected result is awaited; the block is then idle.
  task automatic wait_drained();
    send_item(OP_QUERY, 8'($urandom_range(NIRQ - 1)), now_ts);
    in_valid <= 1'b0;
    while (query_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_tpu(input logic [15:0] v);
    wait_drained();
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tpu = v;
  endtask

  task automatic test_reset_state();
    for (int i = 0; i < 8; i++) send_item(OP_QUERY, 8'($urandom_range(NIRQ - 1)), next_ts());
    send_item(OP_QUERY, 8'd128, next_ts());
    send_item(OP_QUERY, 8'd200, next_ts());
    send_item(OP_QUERY, 8'd255, next_ts());
    wait_drained();
  endtask

  task automatic test_lifecycle();
    logic [7:0] n;
    for (int k = 0; k < 20; k++) begin
      n = 8'($urandom_range(NIRQ - 1));
      send_item(OP_EARLY, 8'($urandom_range(255)), next_ts());
      send_item(OP_ENTER, n, next_ts());
      send_item(OP_EXIT, n, next_ts());
      send_item(OP_DEFER, n, next_ts());
      send_item(OP_LEAVE, n, next_ts());
      send_item(OP_QUERY, n, next_ts());
    end
    wait_drained();
  endtask

  task automatic test_bad_requests();
    repeat (40) send_random(100);
    for (int i = 0; i < 10; i++) send_item(OP_QUERY, 8'($urandom_range(7)), next_ts());
    wait_drained();
  endtask

  task automatic test_config();
    logic [15:0] vals [5];
    vals = '{16'd1, 16'd0, 16'd65535, 16'd3, 16'd24};
    for (int i = 0; i < 5; i++) begin
      write_tpu(vals[i]);
      repeat (30) send_random(5);
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_len = 400;
    hold_req++;
    send_item(OP_QUERY, 8'($urandom_range(7)), next_ts());
    repeat (150) send_random(5);
    wait_drained();
  endtask

  task automatic test_no_idle();
    idle_pct = 0;
    repeat (200) send_random(5);
    wait_drained();
    idle_pct = 29;
  endtask

  task automatic test_random_mix();
    repeat (400) send_random(5);
    wait_drained();
  endtask

  initial begin
    errors = 0;
    idle_pct = 29;
    hold_len = 0;
    hold_req = 0;
    now_ts = 64'd1000;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    rst_n <= 1'b0;
    model_reset();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_lifecycle();
    test_bad_requests();
    test_config();
    test_backpressure();
    test_no_idle();
    test_random_mix();
    if (errors == 0 && query_q.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

>>> filelist.f
rtl/core/irqlp_pkg.sv
rtl/core/irqlp_fifo.sv
rtl/core/irqlp_front.sv
rtl/core/irqlp_div.sv
rtl/core/irqlp_back.sv
rtl/core/irq_latency_profiler.sv
test/tb_irq_latency_profiler.sv
